>>> design/abtg_pkg.sv
// Shared types, constants, sine table builder and micro-program for the accel rotation block.
package abtg_pkg;

    // Default configuration of the sine lookup
    localparam int DEF_SINE_TABLE_DEPTH = 1024;
    localparam int DEF_TRIG_FRAC_BITS   = 15;

    // Angle constants, half angles in 1/128 degree
    localparam int QUARTER       = 11520;
    localparam int HALF_QUARTER  = 5760;
    localparam int FULL_TURN     = 46080;
    localparam int HEADING_SHIFT = 11520;

    // pi/2 in Q60
    localparam logic [63:0] PI_HALF_Q60 = 64'h1921FB54442D1847;

    // Field widths
    localparam int ACCEL_W   = 24;
    localparam int ANGLE_W   = 16;
    localparam int STAMP_W   = 48;
    localparam int HEADING_W = 17;
    localparam int ELAPSED_W = 49;
    localparam int NORM_W    = 49;
    localparam int THRESH_W  = 48;

    // Configuration register indexes
    localparam logic [0:0] CFG_THRESHOLD  = 1'b0;
    localparam logic [0:0] CFG_MAP_ORIENT = 1'b1;

    // Register file addresses
    typedef logic [4:0] reg_t;
    localparam reg_t R_CY  = 5'd0;
    localparam reg_t R_SY  = 5'd1;
    localparam reg_t R_CP  = 5'd2;
    localparam reg_t R_SP  = 5'd3;
    localparam reg_t R_CR  = 5'd4;
    localparam reg_t R_SR  = 5'd5;
    localparam reg_t R_T0  = 5'd6;
    localparam reg_t R_T1  = 5'd7;
    localparam reg_t R_T2  = 5'd8;
    localparam reg_t R_T3  = 5'd9;
    localparam reg_t R_W   = 5'd10;
    localparam reg_t R_X   = 5'd11;
    localparam reg_t R_Y   = 5'd12;
    localparam reg_t R_Z   = 5'd13;
    localparam reg_t R_R00 = 5'd14;
    localparam reg_t R_R01 = 5'd15;
    localparam reg_t R_R02 = 5'd16;
    localparam reg_t R_R10 = 5'd17;
    localparam reg_t R_R11 = 5'd18;
    localparam reg_t R_R12 = 5'd19;
    localparam reg_t R_R20 = 5'd20;
    localparam reg_t R_R21 = 5'd21;
    localparam reg_t R_R22 = 5'd22;
    localparam reg_t R_AX  = 5'd23;
    localparam reg_t R_AY  = 5'd24;
    localparam reg_t R_AZ  = 5'd25;
    localparam reg_t R_GX  = 5'd26;
    localparam reg_t R_GY  = 5'd27;
    localparam reg_t R_GZ  = 5'd28;
    localparam int   RF_DEPTH = 29;

    // Micro-op kinds: accumulate rounded products, raw products, or norm products
    typedef enum logic [1:0] {
        K_RND = 2'd0,
        K_RAW = 2'd1,
        K_NRM = 2'd2
    } kind_t;

    // Writeback modes
    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_PLAIN = 2'd1,
        WR_DBL   = 2'd2,
        WR_SAT   = 2'd3
    } wr_t;

    typedef struct packed {
        logic  vld;
        kind_t kind;
        logic  clr;
        logic  sub;
        wr_t   wr;
        reg_t  dst;
        reg_t  sa;
        reg_t  sb;
    } op_t;

    typedef struct packed {
        logic vld;
        reg_t dst;
    } trig_tag_t;

    localparam int NUM_OPS     = 48;
    localparam int TRIG_ANGLES = 6;
    localparam int TRIG_LAT    = 5;

    // Q60 multiply keeping bits 123:60 of the full product
    function automatic logic [63:0] mulq60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // Taylor sum of sin(x), x in Q60, 14 terms, elaboration only
    function automatic logic [63:0] sine_q60(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = mulq60(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n <= 13; n++) begin
            term = mulq60(term, x2) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    function automatic op_t mk(input kind_t k, input logic c, input logic s, input wr_t w,
                               input reg_t d, input reg_t a, input reg_t b);
        op_t o;
        o.vld  = 1'b1;
        o.kind = k;
        o.clr  = c;
        o.sub  = s;
        o.wr   = w;
        o.dst  = d;
        o.sa   = a;
        o.sb   = b;
        return o;
    endfunction

    // Micro-program: quaternion, rotation matrix, rotated vector, squared norm
    function automatic op_t prog_op(input logic [5:0] step);
        op_t o;
        o = '0;
        case (step)
            6'd0:  o = mk(K_RND, 1'b1, 1'b0, WR_PLAIN, R_T0, R_CY, R_CP);
            6'd1:  o = mk(K_RND, 1'b1, 1'b0, WR_PLAIN, R_T1, R_SY, R_SP);
            6'd2:  o = mk(K_RND, 1'b1, 1'b0, WR_PLAIN, R_T2, R_CY, R_SP);
            6'd3:  o = mk(K_RND, 1'b1, 1'b0, WR_PLAIN, R_T3, R_SY, R_CP);
            6'd4:  o = mk(K_RND, 1'b1, 1'b0, WR_NONE,  R_W, R_T0, R_CR);
            6'd5:  o = mk(K_RND, 1'b0, 1'b1, WR_PLAIN, R_W, R_T1, R_SR);
            6'd6:  o = mk(K_RND, 1'b1, 1'b0, WR_NONE,  R_X, R_T2, R_CR);
            6'd7:  o = mk(K_RND, 1'b0, 1'b1, WR_PLAIN, R_X, R_T3, R_SR);
            6'd8:  o = mk(K_RND, 1'b1, 1'b0, WR_NONE,  R_Y, R_T0, R_SR);
            6'd9:  o = mk(K_RND, 1'b0, 1'b0, WR_PLAIN, R_Y, R_T1, R_CR);
            6'd10: o = mk(K_RND, 1'b1, 1'b0, WR_NONE,  R_Z, R_T2, R_SR);
            6'd11: o = mk(K_RND, 1'b0, 1'b0, WR_PLAIN, R_Z, R_T3, R_CR);
            6'd12: o = mk(K_RND, 1'b1, 1'b0, WR_NONE,  R_R00, R_W, R_W);
            6'd13: o = mk(K_RND, 1'b0, 1'b0, WR_NONE,  R_R00, R_X, R_X);
            6'd14: o = mk(K_RND, 1'b0, 1'b1, WR_NONE,  R_R00, R_Y, R_Y);
            6'd15: o = mk(K_RND, 1'b0, 1'b1, WR_PLAIN, R_R00, R_Z, R_Z);
            6'd16: o = mk(K_RND, 1'b1, 1'b0, WR_NONE,  R_R11, R_W, R_W);
            6'd17: o = mk(K_RND, 1'b0, 1'b1, WR_NONE,  R_R11, R_X, R_X);
            6'd18: o = mk(K_RND, 1'b0, 1'b0, WR_NONE,  R_R11, R_Y, R_Y);
            6'd19: o = mk(K_RND, 1'b0, 1'b1, WR_PLAIN, R_R11, R_Z, R_Z);
            6'd20: o = mk(K_RND, 1'b1, 1'b0, WR_NONE,  R_R22, R_W, R_W);
            6'd21: o = mk(K_RND, 1'b0, 1'b1, WR_NONE,  R_R22, R_X, R_X);
            6'd22: o = mk(K_RND, 1'b0, 1'b1, WR_NONE,  R_R22, R_Y, R_Y);
            6'd23: o = mk(K_RND, 1'b0, 1'b0, WR_PLAIN, R_R22, R_Z, R_Z);
            6'd24: o = mk(K_RND, 1'b1, 1'b0, WR_NONE,  R_R01, R_X, R_Y);
            6'd25: o = mk(K_RND, 1'b0, 1'b1, WR_DBL,   R_R01, R_W, R_Z);
            6'd26: o = mk(K_RND, 1'b1, 1'b0, WR_NONE,  R_R02, R_X, R_Z);
            6'd27: o = mk(K_RND, 1'b0, 1'b0, WR_DBL,   R_R02, R_W, R_Y);
            6'd28: o = mk(K_RND, 1'b1, 1'b0, WR_NONE,  R_R10, R_X, R_Y);
            6'd29: o = mk(K_RND, 1'b0, 1'b0, WR_DBL,   R_R10, R_W, R_Z);
            6'd30: o = mk(K_RND, 1'b1, 1'b0, WR_NONE,  R_R12, R_Y, R_Z);
            6'd31: o = mk(K_RND, 1'b0, 1'b1, WR_DBL,   R_R12, R_W, R_X);
            6'd32: o = mk(K_RND, 1'b1, 1'b0, WR_NONE,  R_R20, R_X, R_Z);
            6'd33: o = mk(K_RND, 1'b0, 1'b1, WR_DBL,   R_R20, R_W, R_Y);
            6'd34: o = mk(K_RND, 1'b1, 1'b0, WR_NONE,  R_R21, R_Y, R_Z);
            6'd35: o = mk(K_RND, 1'b0, 1'b0, WR_DBL,   R_R21, R_W, R_X);
            6'd36: o = mk(K_RAW, 1'b1, 1'b0, WR_NONE,  R_GX, R_R00, R_AX);
            6'd37: o = mk(K_RAW, 1'b0, 1'b0, WR_NONE,  R_GX, R_R01, R_AY);
            6'd38: o = mk(K_RAW, 1'b0, 1'b0, WR_SAT,   R_GX, R_R02, R_AZ);
            6'd39: o = mk(K_RAW, 1'b1, 1'b0, WR_NONE,  R_GY, R_R10, R_AX);
            6'd40: o = mk(K_RAW, 1'b0, 1'b0, WR_NONE,  R_GY, R_R11, R_AY);
            6'd41: o = mk(K_RAW, 1'b0, 1'b0, WR_SAT,   R_GY, R_R12, R_AZ);
            6'd42: o = mk(K_RAW, 1'b1, 1'b0, WR_NONE,  R_GZ, R_R20, R_AX);
            6'd43: o = mk(K_RAW, 1'b0, 1'b0, WR_NONE,  R_GZ, R_R21, R_AY);
            6'd44: o = mk(K_RAW, 1'b0, 1'b0, WR_SAT,   R_GZ, R_R22, R_AZ);
            6'd45: o = mk(K_NRM, 1'b1, 1'b0, WR_NONE,  R_GX, R_GX, R_GX);
            6'd46: o = mk(K_NRM, 1'b0, 1'b0, WR_NONE,  R_GY, R_GY, R_GY);
            6'd47: o = mk(K_NRM, 1'b0, 1'b0, WR_NONE,  R_GZ, R_GZ, R_GZ);
            default: o = '0;
        endcase
        return o;
    endfunction

endpackage

>>> design/abtg_trig.sv
// Pipelined half-angle sine lookup: angle reduction, index scaling and quarter-wave table.
module abtg_trig
    import abtg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
    parameter int TRIG_FRAC_BITS   = DEF_TRIG_FRAC_BITS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  trig_tag_t                      req,
    input  logic signed [17:0]             angle,
    output trig_tag_t                      rsp,
    output logic signed [TRIG_FRAC_BITS+1:0] value
);

    localparam int F       = TRIG_FRAC_BITS;
    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int NUM_W   = 14 + IDX_W;
    localparam int DIVM_W  = NUM_W - 8;
    localparam int RSHIFT  = 28;
    localparam int RECIP   = ((1 << RSHIFT) + 44) / 45;
    localparam int PROD_W  = DIVM_W + 23;

    // Quarter-wave sine table, built at elaboration
    logic [F:0] rom [0:SINE_TABLE_DEPTH];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [63:0] XK = (PI_HALF_Q60 / 64'(SINE_TABLE_DEPTH)) * 64'(k)
            + ((PI_HALF_Q60 % 64'(SINE_TABLE_DEPTH)) * 64'(k)) / 64'(SINE_TABLE_DEPTH);
        localparam logic [63:0] SK = sine_q60(XK);
        localparam logic [63:0] RK = (SK + (64'd1 << (59 - F))) >> (60 - F);
        assign rom[k] = RK[F:0];
    end

    trig_tag_t             tag1_reg, tag2_reg, tag3_reg, tag4_reg, tag5_reg;
    logic [1:0]            q1_reg, q2_reg, q3_reg, q4_reg;
    logic [13:0]           p1_reg;
    logic [DIVM_W-1:0]     m2_reg;
    logic [PROD_W-1:0]     prod3_reg;
    logic [F:0]            rom_q_reg;
    logic signed [F+1:0]   value_reg;

    // Reduce modulo a full turn, split into quadrant and offset
    logic signed [18:0] a_ext;
    logic signed [18:0] r_pos;
    logic [15:0]        r_mod;
    logic [1:0]         q_next;
    logic [15:0]        p_full;

    always_comb
    begin
        a_ext = 19'(angle);
        r_pos = a_ext[18] ? (a_ext + 19'sd92160) : a_ext;
        if (r_pos >= 19'sd46080)
            r_mod = 16'(r_pos - 19'sd46080);
        else
            r_mod = 16'(r_pos);
        if (r_mod >= 16'd34560)
        begin
            q_next = 2'd3;
            p_full = r_mod - 16'd34560;
        end
        else if (r_mod >= 16'd23040)
        begin
            q_next = 2'd2;
            p_full = r_mod - 16'd23040;
        end
        else if (r_mod >= 16'd11520)
        begin
            q_next = 2'd1;
            p_full = r_mod - 16'd11520;
        end
        else
        begin
            q_next = 2'd0;
            p_full = r_mod;
        end
    end

    // Index scaling: (p*DEPTH + half quarter) / 11520, as >>8 then /45 by reciprocal
    logic [NUM_W-1:0] num;
    assign num = NUM_W'(p1_reg) * NUM_W'(SINE_TABLE_DEPTH) + NUM_W'(HALF_QUARTER);

    logic [IDX_W-1:0] idx_raw;
    logic [IDX_W-1:0] idx_clamp;
    logic [IDX_W-1:0] addr;

    always_comb
    begin
        idx_raw = prod3_reg[RSHIFT +: IDX_W];
        if (idx_raw > IDX_W'(SINE_TABLE_DEPTH))
            idx_clamp = IDX_W'(SINE_TABLE_DEPTH);
        else
            idx_clamp = idx_raw;
        // odd quadrants read the mirrored entry
        if (q3_reg[0])
            addr = IDX_W'(SINE_TABLE_DEPTH) - idx_clamp;
        else
            addr = idx_clamp;
    end

    // Tag pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
        end
        else
        begin
            tag1_reg <= req;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
        end
    end

    // Data pipeline
    always_ff @(posedge clk)
    begin
        q1_reg    <= q_next;
        p1_reg    <= p_full[13:0];
        q2_reg    <= q1_reg;
        m2_reg    <= num[NUM_W-1:8];
        q3_reg    <= q2_reg;
        prod3_reg <= PROD_W'(m2_reg) * PROD_W'(RECIP);
        q4_reg    <= q3_reg;
        rom_q_reg <= rom[addr];
        // lower half-turn is negative
        if (q4_reg[1])
            value_reg <= -$signed({1'b0, rom_q_reg});
        else
            value_reg <= $signed({1'b0, rom_q_reg});
    end

    assign rsp   = tag5_reg;
    assign value = value_reg;

endmodule

>>> design/abtg_alu.sv
// Shared multiply-accumulate unit with register file, runs one micro-op per cycle.
module abtg_alu
    import abtg_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = DEF_TRIG_FRAC_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  trig_tag_t                         trig_rsp,
    input  logic signed [TRIG_FRAC_BITS+1:0]  trig_value,
    input  op_t                               op,
    input  logic signed [ACCEL_W-1:0]         accel_x,
    input  logic signed [ACCEL_W-1:0]         accel_y,
    input  logic signed [ACCEL_W-1:0]         accel_z,
    output logic signed [ACCEL_W-1:0]         global_x,
    output logic signed [ACCEL_W-1:0]         global_y,
    output logic signed [ACCEL_W-1:0]         global_z,
    output logic [NORM_W-1:0]                 norm
);

    localparam int F  = TRIG_FRAC_BITS;
    localparam int W  = (F + 5 > 25) ? F + 5 : 25;
    localparam int PW = 2 * W;
    localparam int AW = PW + 2;

    logic signed [W-1:0]  rf [0:RF_DEPTH-1];
    logic signed [W-1:0]  a_reg, b_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg;
    logic [NORM_W-1:0]    norm_reg;
    logic signed [ACCEL_W-1:0] gx_reg, gy_reg, gz_reg;
    op_t                  op1_reg, op2_reg;

    // Shift right by F, round half away from zero
    function automatic logic signed [AW-1:0] rnd_q(input logic signed [AW-1:0] v);
        logic [AW-1:0] m;
        m = v[AW-1] ? AW'(-v) : AW'(v);
        m = (m + (AW'(1) << (F - 1))) >> F;
        return v[AW-1] ? -$signed(m) : $signed(m);
    endfunction

    // Operand B comes from the input registers for the acceleration entries
    logic signed [W-1:0] b_sel;
    always_comb
    begin
        if (op.sb == R_AX)
            b_sel = W'(accel_x);
        else if (op.sb == R_AY)
            b_sel = W'(accel_y);
        else if (op.sb == R_AZ)
            b_sel = W'(accel_z);
        else
            b_sel = rf[op.sb];
    end

    // Accumulate stage
    logic signed [AW-1:0]      prod_ext, term, acc_base, acc_new, rsum;
    logic signed [ACCEL_W-1:0] sat_val;
    logic signed [W-1:0]       wb_val;
    logic                      wb_en;

    always_comb
    begin
        prod_ext = AW'(prod_reg);
        term     = (op2_reg.kind == K_RND) ? rnd_q(prod_ext) : prod_ext;
        acc_base = op2_reg.clr ? '0 : acc_reg;
        acc_new  = op2_reg.sub ? (acc_base - term) : (acc_base + term);
        rsum     = rnd_q(acc_new);
        // saturate to 24 bits when the upper bits are not a sign extension
        if ((&rsum[AW-1:ACCEL_W-1]) || !(|rsum[AW-1:ACCEL_W-1]))
            sat_val = rsum[ACCEL_W-1:0];
        else if (rsum[AW-1])
            sat_val = {1'b1, {(ACCEL_W-1){1'b0}}};
        else
            sat_val = {1'b0, {(ACCEL_W-1){1'b1}}};
        case (op2_reg.wr)
            WR_PLAIN: wb_val = acc_new[W-1:0];
            WR_DBL:   wb_val = {acc_new[W-2:0], 1'b0};
            WR_SAT:   wb_val = W'(sat_val);
            default:  wb_val = '0;
        endcase
        wb_en = op2_reg.vld && (op2_reg.wr != WR_NONE) && (op2_reg.kind != K_NRM);
    end

    // Control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op1_reg <= '0;
            op2_reg <= '0;
        end
        else
        begin
            op1_reg <= op;
            op2_reg <= op1_reg;
        end
    end

    // Register file: one write port, two registered reads
    always_ff @(posedge clk)
    begin
        if (trig_rsp.vld)
            rf[trig_rsp.dst] <= W'(trig_value);
        else if (wb_en)
            rf[op2_reg.dst] <= wb_val;
        a_reg <= rf[op.sa];
        b_reg <= b_sel;
    end

    // Multiplier, accumulators and result registers
    always_ff @(posedge clk)
    begin
        prod_reg <= a_reg * b_reg;
        if (op2_reg.vld && (op2_reg.kind != K_NRM))
            acc_reg <= acc_new;
        if (op2_reg.vld && (op2_reg.kind == K_NRM))
            norm_reg <= (op2_reg.clr ? '0 : norm_reg) + prod_reg[NORM_W-1:0];
        if (wb_en && (op2_reg.wr == WR_SAT))
        begin
            case (op2_reg.dst)
                R_GX:    gx_reg <= sat_val;
                R_GY:    gy_reg <= sat_val;
                default: gz_reg <= sat_val;
            endcase
        end
    end

    assign global_x = gx_reg;
    assign global_y = gy_reg;
    assign global_z = gz_reg;
    assign norm     = norm_reg;

endmodule

>>> design/accel_body_to_global_rotation.sv
// Top level: stream handshake, sequencer, config registers, heading and timing outputs.
//
// Rotates one body-frame acceleration sample into global axes.
// Input channel s_*: one transaction carries accel x/y/z, pitch, roll, yaw and a
// timestamp. Output channel m_*: one transaction per input with the rotated,
// saturated vector, heading, timestamp and elapsed time; m_tuser flags a
// stationary sample (squared norm below the threshold register).
// Config: cfg_wr_en/cfg_index/cfg_data, index 0 threshold, 1 map orientation;
// write only while the block is idle.
// Processing: the six sine lookups run through the table pipeline, then the 48
// micro-ops run through the single shared multiply-accumulate unit plus its
// pipeline drain, and finally the output register is loaded.
// The block takes no new sample until it has finished the last one; s_tready
// is high only while idle.
// The output register holds a finished result while m_tready is low; the next
// sample is still taken, but its result waits until the register is free.
// Reset clears the handshakes, the config registers and the previous-time state,
// so the first sample after reset reports zero elapsed time.
module accel_body_to_global_rotation
    import abtg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH,
    parameter int TRIG_FRAC_BITS   = DEF_TRIG_FRAC_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // accel_x, accel_y, accel_z, pitch_angle, roll_angle, yaw_angle, sample_time
    input  logic [167:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // global_x, global_y, global_z, heading, stamp_out, elapsed, zero pad
    output logic [191:0]  m_tdata,
    // is_still
    output logic          m_tuser,
    input  logic          cfg_wr_en,
    input  logic [0:0]    cfg_index,
    input  logic [47:0]   cfg_data
);

    localparam int TRIG_CYCLES = TRIG_ANGLES + TRIG_LAT;
    localparam int RUN_CYCLES  = NUM_OPS + 3;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_TRIG = 4'b0010,
        ST_RUN  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;

    logic [THRESH_W-1:0]         thresh_reg;
    logic signed [ANGLE_W-1:0]   map_reg;
    logic [STAMP_W-1:0]          prev_time_reg;
    logic                        seen_reg;

    logic signed [ACCEL_W-1:0]   ax_reg, ay_reg, az_reg;
    logic signed [ANGLE_W-1:0]   pitch_reg, roll_reg;
    logic signed [HEADING_W-1:0] s_reg;
    logic [STAMP_W-1:0]          stamp_reg;
    logic [ELAPSED_W-1:0]        elapsed_reg;

    logic                        out_vld_reg;
    logic [191:0]                out_data_reg;
    logic                        out_still_reg;

    logic in_acc, out_free;
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_acc)
                    state_next = ST_TRIG;
            end
            ST_TRIG:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(TRIG_CYCLES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(RUN_CYCLES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= '0;
            map_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:  thresh_reg <= cfg_data;
                CFG_MAP_ORIENT: map_reg    <= cfg_data[ANGLE_W-1:0];
                default:        thresh_reg <= thresh_reg;
            endcase
        end
    end

    // Previous timestamp state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg <= '0;
            seen_reg      <= 1'b0;
        end
        else if (in_acc)
        begin
            prev_time_reg <= s_tdata[167:120];
            seen_reg      <= 1'b1;
        end
    end

    // Capture the input transaction
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ax_reg    <= s_tdata[23:0];
            ay_reg    <= s_tdata[47:24];
            az_reg    <= s_tdata[71:48];
            pitch_reg <= s_tdata[87:72];
            roll_reg  <= s_tdata[103:88];
            s_reg     <= HEADING_W'($signed(s_tdata[119:104])) + HEADING_W'(map_reg);
            stamp_reg <= s_tdata[167:120];
            if (seen_reg)
                elapsed_reg <= {1'b0, s_tdata[167:120]} - {1'b0, prev_time_reg};
            else
                elapsed_reg <= '0;
        end
    end

    // Sine lookup requests, one angle per cycle
    trig_tag_t          trig_req, trig_rsp;
    logic signed [17:0] trig_angle;
    logic signed [TRIG_FRAC_BITS+1:0] trig_value;

    always_comb
    begin
        trig_req.vld = (state_reg == ST_TRIG) && (cnt_reg < 6'(TRIG_ANGLES));
        trig_req.dst = cnt_reg[4:0];
        case (trig_req.dst)
            R_CY:    trig_angle = 18'(s_reg) + 18'sd11520;
            R_SY:    trig_angle = 18'(s_reg);
            R_CP:    trig_angle = 18'(pitch_reg) + 18'sd11520;
            R_SP:    trig_angle = 18'(pitch_reg);
            R_CR:    trig_angle = 18'(roll_reg) + 18'sd11520;
            default: trig_angle = 18'(roll_reg);
        endcase
    end

    abtg_trig #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .TRIG_FRAC_BITS   (TRIG_FRAC_BITS)
    ) u_trig (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (trig_req),
        .angle (trig_angle),
        .rsp   (trig_rsp),
        .value (trig_value)
    );

    // Micro-op issue
    op_t op;
    always_comb
    begin
        if ((state_reg == ST_RUN) && (cnt_reg < 6'(NUM_OPS)))
            op = prog_op(cnt_reg);
        else
            op = '0;
    end

    logic signed [ACCEL_W-1:0] gx, gy, gz;
    logic [NORM_W-1:0]         norm;

    abtg_alu #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_alu (
        .clk        (clk),
        .rst_n      (rst_n),
        .trig_rsp   (trig_rsp),
        .trig_value (trig_value),
        .op         (op),
        .accel_x    (ax_reg),
        .accel_y    (ay_reg),
        .accel_z    (az_reg),
        .global_x   (gx),
        .global_y   (gy),
        .global_z   (gz),
        .norm       (norm)
    );

    // Heading: shift by half a turn toward zero
    logic signed [HEADING_W:0] heading_wide;
    always_comb
    begin
        if (s_reg > 0)
            heading_wide = (HEADING_W + 1)'(s_reg) - (HEADING_W + 1)'(HEADING_SHIFT);
        else
            heading_wide = (HEADING_W + 1)'(s_reg) + (HEADING_W + 1)'(HEADING_SHIFT);
    end

    // Output register
    logic load_out;
    assign load_out = (state_reg == ST_OUT) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (load_out)
            out_vld_reg <= 1'b1;
        else if (m_tready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg  <= {6'd0, elapsed_reg, stamp_reg, heading_wide[HEADING_W-1:0],
                              gz, gy, gx};
            out_still_reg <= (norm < {1'b0, thresh_reg});
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_still_reg;

endmodule
